@@ hdl/fdc_pkg.sv @@
`default_nettype none

package fdc_pkg;

    // Frame type bytes
    localparam logic [7:0] TYPE_NORMAL_BYTE = 8'h53;
    localparam logic [7:0] TYPE_DEBUG_BYTE  = 8'h43;

    // Stored frame type
    localparam logic [1:0] FT_NORMAL  = 2'd0;
    localparam logic [1:0] FT_DEBUG   = 2'd1;
    localparam logic [1:0] FT_UNKNOWN = 2'd2;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Frame status codes
    localparam logic [2:0] ST_NORMAL  = 3'd0;
    localparam logic [2:0] ST_BAD_SUM = 3'd3;
    localparam logic [2:0] ST_TRUNC   = 3'd4;
    localparam logic [2:0] ST_BAD_LEN = 3'd5;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_transfer;
    } item_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_byte;
        logic [7:0]  command_code;
        logic [2:0]  frame_status;
        logic [15:0] payload_count;
        logic        last_of_run;
    } result_t;

    // Results produced by one transaction: count is 0, 1 or 2
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

`default_nettype wire

@@ hdl/frame_deframer_checksum_core.sv @@
// Results are registered into the output queue as their bytes are accepted.
// Throughput: one byte per cycle while the three-entry queue holds at most one
// result; a byte that yields a payload plus a truncated status pushes both.
// Reset (rst_n low, asynchronous): parser expects a type byte, queue empty.
`default_nettype none

module frame_deframer_checksum_core
    import fdc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_ready,
    input  wire item_t   item,
    output logic         result_valid,
    input  wire logic    result_ready,
    output result_t      result
);

    logic  accept;
    logic  space;
    push_t push;

    assign item_ready = space;
    assign accept     = item_valid && space;

    fdc_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .push   (push)
    );

    fdc_out_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .space        (space),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

@@ hdl/fdc_parser.sv @@
`default_nettype none

module fdc_parser
    import fdc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  accept,
    input  wire item_t item,
    output push_t      push
);

    typedef enum logic [2:0] {
        PH_TYPE,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_CMD,
        PH_PAYLOAD,
        PH_CHECK,
        PH_DRAIN
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [7:0]  sum_reg, sum_next;
    logic [1:0]  ftype_reg, ftype_next;
    logic [7:0]  command_reg, command_next;

    logic [7:0]  b;
    logic [15:0] count_cur;
    logic [15:0] length_full;
    logic        status_done;
    logic [1:0]  n_main;
    logic        trunc;
    logic        count_known;
    logic        cmd_known;
    result_t     main_res;
    result_t     trunc_res;

    assign b           = item.rx_byte;
    assign count_cur   = length_reg - 16'd2;
    assign length_full = {b, length_reg[7:0]};

    // Parse one byte against the current phase
    always_comb
    begin
        phase_next     = phase_reg;
        length_next    = length_reg;
        remaining_next = remaining_reg;
        sum_next       = sum_reg;
        ftype_next     = ftype_reg;
        command_next   = command_reg;
        status_done    = 1'b0;
        n_main         = 2'd0;
        main_res       = '0;

        unique case (phase_reg)
            PH_TYPE:
            begin
                if (b == TYPE_NORMAL_BYTE)
                    ftype_next = FT_NORMAL;
                else if (b == TYPE_DEBUG_BYTE)
                    ftype_next = FT_DEBUG;
                else
                    ftype_next = FT_UNKNOWN;
                sum_next       = b;
                length_next    = '0;
                remaining_next = '0;
                command_next   = '0;
                phase_next     = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                length_next = {8'd0, b};
                sum_next    = sum_reg + b;
                phase_next  = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                length_next = length_full;
                sum_next    = sum_reg + b;
                if (length_full < 16'd2)
                begin
                    main_res.result_kind  = KIND_STATUS;
                    main_res.frame_status = ST_BAD_LEN;
                    main_res.last_of_run  = 1'b1;
                    n_main                = 2'd1;
                    status_done           = 1'b1;
                    phase_next            = PH_DRAIN;
                end
                else
                begin
                    phase_next = PH_CMD;
                end
            end
            PH_CMD:
            begin
                command_next   = b;
                sum_next       = sum_reg + b;
                remaining_next = count_cur;
                phase_next     = (count_cur != 16'd0) ? PH_PAYLOAD : PH_CHECK;
            end
            PH_PAYLOAD:
            begin
                main_res.result_kind   = KIND_PAYLOAD;
                main_res.payload_byte  = b;
                main_res.command_code  = command_reg;
                main_res.payload_count = count_cur;
                main_res.last_of_run   = 1'b1;
                n_main                 = 2'd1;
                sum_next               = sum_reg + b;
                remaining_next         = remaining_reg - 16'd1;
                if (remaining_next == 16'd0)
                    phase_next = PH_CHECK;
            end
            PH_CHECK:
            begin
                main_res.result_kind   = KIND_STATUS;
                main_res.command_code  = command_reg;
                main_res.frame_status  = (b == sum_reg) ? {1'b0, ftype_reg} : ST_BAD_SUM;
                main_res.payload_count = count_cur;
                main_res.last_of_run   = 1'b1;
                n_main                 = 2'd1;
                status_done            = 1'b1;
                phase_next             = PH_DRAIN;
            end
            default:
            begin
                phase_next = PH_DRAIN;
            end
        endcase

        // Close an unfinished frame at the end of the transfer
        trunc       = item.end_of_transfer && !status_done && (phase_next != PH_DRAIN);
        count_known = (phase_next == PH_CMD || phase_next == PH_PAYLOAD
                       || phase_next == PH_CHECK) && (length_next >= 16'd2);
        cmd_known   = (phase_next == PH_PAYLOAD || phase_next == PH_CHECK);

        trunc_res               = '0;
        trunc_res.result_kind   = KIND_STATUS;
        trunc_res.command_code  = cmd_known ? command_next : 8'd0;
        trunc_res.frame_status  = ST_TRUNC;
        trunc_res.payload_count = count_known ? (length_next - 16'd2) : 16'd0;
        trunc_res.last_of_run   = 1'b1;

        push = '0;
        if (accept)
        begin
            if (trunc && (n_main != 2'd0))
            begin
                push.first             = main_res;
                push.first.last_of_run = 1'b0;
                push.second            = trunc_res;
                push.count             = 2'd2;
            end
            else if (trunc)
            begin
                push.first = trunc_res;
                push.count = 2'd1;
            end
            else
            begin
                push.first = main_res;
                push.count = n_main;
            end
        end

        if (item.end_of_transfer)
            phase_next = PH_TYPE;
    end

    // Hold parser state, advance on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_TYPE;
            length_reg    <= '0;
            remaining_reg <= '0;
            sum_reg       <= '0;
            ftype_reg     <= FT_NORMAL;
            command_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            length_reg    <= length_next;
            remaining_reg <= remaining_next;
            sum_reg       <= sum_next;
            ftype_reg     <= ftype_next;
            command_reg   <= command_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_eot_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.end_of_transfer) |=> (phase_reg == PH_TYPE))
        else $error("parser did not return to type phase after transfer end");

    a_pair_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |-> (push.first.result_kind == KIND_PAYLOAD
            && !push.first.last_of_run && push.second.frame_status == ST_TRUNC))
        else $error("two results must be payload then truncated status");

    a_drain_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_DRAIN) |-> (push.count == 2'd0))
        else $error("trailing byte produced a result");
`endif

endmodule

`default_nettype wire

@@ hdl/fdc_out_queue.sv @@
`default_nettype none

module fdc_out_queue
    import fdc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire push_t   push,
    output logic         space,
    output logic         result_valid,
    input  wire logic    result_ready,
    output result_t      result
);

    localparam int QDEPTH = 3;

    result_t    slot_reg [QDEPTH];
    logic [1:0] head_reg, head_next;
    logic [1:0] tail_reg, tail_next;
    logic [1:0] count_reg, count_next;
    logic [1:0] tail_plus1;
    logic       pop;

    function automatic logic [1:0] wrap_inc(input logic [1:0] p);
        return (p == 2'(QDEPTH - 1)) ? 2'd0 : p + 2'd1;
    endfunction

    assign pop          = result_valid && result_ready;
    assign result_valid = (count_reg != 2'd0);
    assign result       = slot_reg[head_reg];
    assign space        = (count_reg <= 2'd1);
    assign tail_plus1   = wrap_inc(tail_reg);

    // Advance pointers by pushes and pops
    always_comb
    begin
        head_next  = pop ? wrap_inc(head_reg) : head_reg;
        count_next = count_reg + push.count - {1'b0, pop};
        case (push.count)
            2'd1:    tail_next = tail_plus1;
            2'd2:    tail_next = wrap_inc(tail_plus1);
            default: tail_next = tail_reg;
        endcase
    end

    // Write up to two results per cycle
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            slot_reg[tail_reg] <= push.first;
        if (push.count == 2'd2)
            slot_reg[tail_plus1] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> (count_reg <= 2'd1))
        else $error("push into queue without room");

    a_status_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last_of_run) |-> (count_reg >= 2'd2))
        else $error("payload without its truncated status behind it");

    a_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && count_reg == 2'd1 && push.count == 2'd0) |=> !result_valid)
        else $error("queue still valid after last result taken");
`endif

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`default_nettype none

module tb_top;
    import fdc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 1200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 8;
    localparam int IDLE_PERCENT   = 17;

    // Parser position within a frame
    typedef enum logic [2:0] {
        WAIT_TYPE,
        WAIT_LEN_LO,
        WAIT_LEN_HI,
        WAIT_CMD,
        IN_PAYLOAD,
        WAIT_SUM,
        SKIP_REST
    } parse_phase_t;

    // One directed stimulus row; want is used only when typed is set
    typedef struct packed {
        item_t   x;
        logic    typed;
        result_t want;
    } dir_row_t;

    typedef struct {
        logic    typed;
        result_t want;
    } offered_row_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_ready;
    item_t   item = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    // Parser state of the prediction
    parse_phase_t phase = WAIT_TYPE;
    logic [15:0]  frame_len = '0;
    logic [15:0]  payload_left = '0;
    logic [7:0]   frame_sum = '0;
    logic [1:0]   frame_kind = '0;
    logic [7:0]   cmd_hold = '0;

    result_t      due_results[$];
    result_t      byte_results[$];
    offered_row_t offered_rows[$];
    item_t        burst[$];
    logic [7:0]   burst_sum;

    int   mismatches = 0;
    int   quiet_cycles = 0;
    logic steady = 1'b0;

    dir_row_t directed_rows [27] = '{
        // length below two, then a trailing byte that closes the transfer
        '{'{8'h53, 1'b0}, 1'b0, '0},
        '{'{8'h01, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b1, '{KIND_STATUS, 8'h00, 8'h00, ST_BAD_LEN, 16'd0, 1'b1}},
        '{'{8'h42, 1'b1}, 1'b0, '0},
        // debug frame, one payload byte, good sum
        '{'{8'h43, 1'b0}, 1'b0, '0},
        '{'{8'h03, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'hFF, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'h45, 1'b1}, 1'b1, '{KIND_STATUS, 8'h00, 8'hFF, {1'b0, FT_DEBUG}, 16'd1, 1'b1}},
        // unknown type, empty payload, wrong sum
        '{'{8'hFF, 1'b0}, 1'b0, '0},
        '{'{8'h02, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b1}, 1'b1, '{KIND_STATUS, 8'h00, 8'h00, ST_BAD_SUM, 16'd0, 1'b1}},
        // longest declared length, cut after one payload byte
        '{'{8'h53, 1'b0}, 1'b0, '0},
        '{'{8'hFF, 1'b0}, 1'b0, '0},
        '{'{8'hFF, 1'b0}, 1'b0, '0},
        '{'{8'h80, 1'b0}, 1'b0, '0},
        '{'{8'hFF, 1'b1}, 1'b0, '0},
        // transfer holding nothing but a type byte
        '{'{8'h00, 1'b1}, 1'b1, '{KIND_STATUS, 8'h00, 8'h00, ST_TRUNC, 16'd0, 1'b1}},
        // normal frame, one payload byte, good sum
        '{'{8'h53, 1'b0}, 1'b0, '0},
        '{'{8'h03, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'h12, 1'b0}, 1'b0, '0},
        '{'{8'h0D, 1'b0}, 1'b0, '0},
        '{'{8'h75, 1'b1}, 1'b1, '{KIND_STATUS, 8'h00, 8'h12, ST_NORMAL, 16'd1, 1'b1}}
    };

    frame_deframer_checksum_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic result_t make_result(logic kind, logic [7:0] data, logic [7:0] cmd,
                                            logic [2:0] status, logic [15:0] count);
        result_t r;
        r.result_kind   = kind;
        r.payload_byte  = data;
        r.command_code  = cmd;
        r.frame_status  = status;
        r.payload_count = count;
        r.last_of_run   = 1'b1;
        return r;
    endfunction

    // Advance the parser by one byte and collect the results it gives
    task automatic deframe_byte(input item_t x);
        logic [7:0]  b;
        logic        closed;
        logic [7:0]  known_cmd;
        logic [15:0] known_cnt;
        b = x.rx_byte;
        closed = 1'b0;
        byte_results.delete();
        case (phase)
            WAIT_TYPE:
            begin
                if (b == TYPE_NORMAL_BYTE)
                    frame_kind = FT_NORMAL;
                else if (b == TYPE_DEBUG_BYTE)
                    frame_kind = FT_DEBUG;
                else
                    frame_kind = FT_UNKNOWN;
                frame_sum = b;
                frame_len = '0;
                payload_left = '0;
                cmd_hold = '0;
                phase = WAIT_LEN_LO;
            end
            WAIT_LEN_LO:
            begin
                frame_len = {8'h00, b};
                frame_sum += b;
                phase = WAIT_LEN_HI;
            end
            WAIT_LEN_HI:
            begin
                frame_len[15:8] = b;
                frame_sum += b;
                if (frame_len < 16'd2)
                begin
                    byte_results.push_back(make_result(KIND_STATUS, 8'h00, 8'h00,
                                                       ST_BAD_LEN, 16'd0));
                    closed = 1'b1;
                    phase = SKIP_REST;
                end
                else
                begin
                    phase = WAIT_CMD;
                end
            end
            WAIT_CMD:
            begin
                cmd_hold = b;
                frame_sum += b;
                payload_left = frame_len - 16'd2;
                phase = (payload_left != 0) ? IN_PAYLOAD : WAIT_SUM;
            end
            IN_PAYLOAD:
            begin
                byte_results.push_back(make_result(KIND_PAYLOAD, b, cmd_hold, ST_NORMAL,
                                                   frame_len - 16'd2));
                frame_sum += b;
                payload_left -= 16'd1;
                if (payload_left == 0)
                    phase = WAIT_SUM;
            end
            WAIT_SUM:
            begin
                byte_results.push_back(make_result(KIND_STATUS, 8'h00, cmd_hold,
                                                   (b == frame_sum) ? {1'b0, frame_kind}
                                                                    : ST_BAD_SUM,
                                                   frame_len - 16'd2));
                closed = 1'b1;
                phase = SKIP_REST;
            end
            default:
            begin
                phase = SKIP_REST;
            end
        endcase

        // Close an unfinished frame as truncated; end of transfer always rearms
        if (x.end_of_transfer)
        begin
            if (!closed && phase != SKIP_REST)
            begin
                known_cnt = (phase inside {WAIT_CMD, IN_PAYLOAD, WAIT_SUM} &&
                             frame_len >= 16'd2) ? frame_len - 16'd2 : 16'd0;
                known_cmd = (phase inside {IN_PAYLOAD, WAIT_SUM}) ? cmd_hold : 8'h00;
                if (byte_results.size() != 0)
                    byte_results[byte_results.size() - 1].last_of_run = 1'b0;
                byte_results.push_back(make_result(KIND_STATUS, 8'h00, known_cmd,
                                                   ST_TRUNC, known_cnt));
            end
            phase = WAIT_TYPE;
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // Compare one transaction against the oldest pending result
    task automatic check_result(input result_t got);
        result_t want;
        if (due_results.size() == 0)
        begin
            report_mismatch($sformatf("result %h with nothing pending", got));
            return;
        end
        want = due_results.pop_front();
        compare_field("result_kind", 16'(got.result_kind), 16'(want.result_kind));
        compare_field("payload_byte", 16'(got.payload_byte), 16'(want.payload_byte));
        compare_field("command_code", 16'(got.command_code), 16'(want.command_code));
        compare_field("frame_status", 16'(got.frame_status), 16'(want.frame_status));
        compare_field("payload_count", got.payload_count, want.payload_count);
        compare_field("last_of_run", 16'(got.last_of_run), 16'(want.last_of_run));
    endtask

    // Watch both channels: check results, predict accepted bytes, guard for hangs
    always @(posedge clk)
    begin : channel_watch
        offered_row_t row;
        logic         moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (result_valid && result_ready)
            begin
                check_result(result);
                moved = 1'b1;
            end
            if (item_valid && item_ready)
            begin
                row = offered_rows.pop_front();
                deframe_byte(item);
                if (row.typed)
                    due_results.push_back(row.want);
                else
                    foreach (byte_results[i])
                        due_results.push_back(byte_results[i]);
                moved = 1'b1;
            end
            if (moved)
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("SCOREBOARD MISMATCH");
                    $finish;
                end
            end
        end
    end

    // Stall the result side at random, except through the steady stretch
    always @(posedge clk)
        result_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);

    // Present one byte, with a random gap first, and hold it until accepted
    task automatic offer(input item_t x, input logic typed, input result_t want);
        offered_row_t row;
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        row.typed = typed;
        row.want = want;
        offered_rows.push_back(row);
        item <= x;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    task automatic add_byte(input logic [7:0] b);
        item_t x;
        x.rx_byte = b;
        x.end_of_transfer = 1'b0;
        burst.push_back(x);
        burst_sum += b;
    endtask

    // Build one transfer: mostly well-formed frames with random content,
    // some bad lengths, wrong sums, trailing bytes, early ends and noise
    task automatic build_transfer();
        int          pick;
        int          plen;
        int          keep;
        logic [7:0]  type_byte;
        logic [15:0] len;
        burst.delete();
        burst_sum = 8'h00;
        pick = $urandom_range(99);
        if (pick < 5)
        begin
            repeat ($urandom_range(4, 1))
                add_byte(8'($urandom()));
        end
        else
        begin
            pick = $urandom_range(99);
            type_byte = (pick < 40) ? TYPE_NORMAL_BYTE :
                        (pick < 80) ? TYPE_DEBUG_BYTE : 8'($urandom());
            pick = $urandom_range(99);
            if (pick < 8)
                len = 16'($urandom_range(1, 0));
            else if (pick < 14)
                len = 16'($urandom());
            else
                len = 16'($urandom_range(9, 2));
            add_byte(type_byte);
            add_byte(len[7:0]);
            add_byte(len[15:8]);
            if (len >= 16'd2)
            begin
                add_byte(8'($urandom()));
                plen = int'(len) - 2;
                if (plen > 12)
                begin
                    // long declaration: stop well before the sum byte
                    repeat ($urandom_range(12, 0))
                        add_byte(8'($urandom()));
                end
                else
                begin
                    repeat (plen)
                        add_byte(8'($urandom()));
                    if ($urandom_range(99) < 15)
                        add_byte(8'($urandom()));
                    else
                        add_byte(burst_sum);
                end
            end
            if ($urandom_range(99) < 15)
                repeat ($urandom_range(3, 1))
                    add_byte(8'($urandom()));
            if ($urandom_range(99) < 10 && burst.size() > 1)
            begin
                keep = $urandom_range(burst.size() - 1, 1);
                while (burst.size() > keep)
                    void'(burst.pop_back());
            end
        end
        burst[burst.size() - 1].end_of_transfer = 1'b1;
    endtask

    initial
    begin : stimulus
        int sent;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (directed_rows[i])
            offer(directed_rows[i].x, directed_rows[i].typed, directed_rows[i].want);

        // Random transfers, with a stretch where neither side idles
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            steady = (sent >= 300 && sent < 600);
            build_transfer();
            foreach (burst[i])
                offer(burst[i], 1'b0, '0);
            sent += burst.size();
        end
        steady = 1'b0;
        item_valid <= 1'b0;

        // Drain what is still pending, then let the pipeline settle
        @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (due_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", due_results.size()));

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
hdl/fdc_pkg.sv
hdl/fdc_parser.sv
hdl/fdc_out_queue.sv
hdl/frame_deframer_checksum_core.sv
tb/tb_top.sv
